@@ design/mfdcd_pkg.sv @@
package mfdcd_pkg;

	localparam int SAMPLES_DEF  = 5;
	localparam int ADC_BITS_DEF = 10;

	localparam int VAL_W      = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int HALF_W     = 7;
	localparam int OUT_W      = 16;

	localparam logic [CFG_ADDR_W-1:0] CFG_DZ_EN  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_CENTER = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_HALF   = 2'd2;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_ACK    = 1'b1;

	localparam logic [VAL_W-1:0]  CENTER_RST = 8'd128;
	localparam logic [HALF_W-1:0] HALF_RST   = 7'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EVAL,
		ST_EMIT
	} mfdcd_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic eval;
		logic emit;
	} mfdcd_cmd_t;

	typedef struct packed {
		logic fill;
		logic out_free;
	} mfdcd_status_t;

endpackage

@@ design/median_five_deadzone_change_detect_top.sv @@
// Median-of-five change detector. Each sample transfer carries a raw
// converter reading in tdata (tuser low) or a consumer acknowledge
// (tuser high). Samples are cut to their top 8 bits and insertion-sorted
// into a small store; every SAMPLES_PER_MEDIAN-th accepted sample yields
// the median, optionally snapped to center_value when it lies strictly
// inside center_value +/- deadzone_half. A median differing from the last
// reported value (or the first median ever) is stored and raises changed
// and ready; an equal one clears changed. While ready is set samples are
// dropped until an acknowledge arrives. Every input transfer produces
// exactly one result transfer with the current value and flags.
// Each item passes through accept, sort insert and emit, with an extra
// deadzone and compare step when it completes a median, plus any
// wait for the output register to drain. Configuration writes are taken
// at any edge with cfg_we high; write only while the block is idle.
module median_five_deadzone_change_detect_top #(
	parameter int SAMPLES_PER_MEDIAN = mfdcd_pkg::SAMPLES_DEF,
	parameter int ADC_BITS           = mfdcd_pkg::ADC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: 0 deadzone_enable, 1 center_value, 2 deadzone_half
	input  logic                             cfg_we,
	input  logic [mfdcd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [mfdcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// sample stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [((ADC_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample, zero pad
	input  logic                             s_axis_tuser,  // mode
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [mfdcd_pkg::OUT_W-1:0]      m_axis_tdata   // value, changed,
	                                                        // ready_res, median_done, pad
);
	import mfdcd_pkg::*;

	mfdcd_cmd_t    cmd;
	mfdcd_status_t status;

	// controller sequences accept / insert / evaluate / emit
	mfdcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: config regs, sorted store, deadzone, change flags, output reg
	mfdcd_dp #(
		.SAMPLES_PER_MEDIAN (SAMPLES_PER_MEDIAN),
		.ADC_BITS           (ADC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_sample (s_axis_tdata[ADC_BITS-1:0]),
		.in_mode   (s_axis_tuser),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

@@ design/mfdcd_ctrl.sv @@
module mfdcd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  mfdcd_pkg::mfdcd_status_t status,
	output mfdcd_pkg::mfdcd_cmd_t    cmd
);
	import mfdcd_pkg::*;

	mfdcd_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step  = 1'b1;
				state_nxt = status.fill ? ST_EVAL : ST_EMIT;
			end
			ST_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

@@ design/mfdcd_dp.sv @@
module mfdcd_dp #(
	parameter int SAMPLES_PER_MEDIAN = mfdcd_pkg::SAMPLES_DEF,
	parameter int ADC_BITS           = mfdcd_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfdcd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [mfdcd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic [ADC_BITS-1:0]                 in_sample,
	input  logic                                in_mode,
	input  mfdcd_pkg::mfdcd_cmd_t               cmd,
	output mfdcd_pkg::mfdcd_status_t            status,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mfdcd_pkg::OUT_W-1:0]         out_data
);
	import mfdcd_pkg::*;

	localparam int N     = SAMPLES_PER_MEDIAN;
	localparam int CNT_W = $clog2(N + 1);
	localparam int MID   = N / 2;

	// config
	logic              dz_en_q;
	logic [VAL_W-1:0]  center_q;
	logic [HALF_W-1:0] half_q;

	// captured item
	logic              mode_q;
	logic [VAL_W-1:0]  byte_q;

	// insertion-sorted sample store, entries at and above count_q are empty
	logic [VAL_W-1:0]  sorted_q   [N];
	logic [VAL_W-1:0]  sorted_nxt [N];
	logic [N-1:0]      gt;
	logic [CNT_W-1:0]  count_q;

	logic              ready_q, changed_q, have_last_q, done_q, out_valid_q;
	logic [VAL_W-1:0]  last_q;

	logic              take_sample;
	logic signed [9:0] med_s, lo_s, hi_s;
	logic [VAL_W-1:0]  snapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_en_q  <= 1'b0;
			center_q <= CENTER_RST;
			half_q   <= HALF_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DZ_EN:  dz_en_q  <= cfg_wdata[0];
				CFG_CENTER: center_q <= cfg_wdata;
				CFG_HALF:   half_q   <= cfg_wdata[HALF_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			byte_q <= in_sample[ADC_BITS-1 -: VAL_W];
		end
	end

	assign take_sample = (mode_q == MODE_SAMPLE) && !ready_q;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			gt[i] = (CNT_W'(i) >= count_q) || (sorted_q[i] > byte_q);
		end
		for (int i = 0; i < N; i++) begin
			if (!gt[i]) begin
				sorted_nxt[i] = sorted_q[i];
			end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
				sorted_nxt[i] = sorted_q[(i > 0) ? i - 1 : 0];
			end else begin
				sorted_nxt[i] = byte_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && take_sample) begin
			sorted_q <= sorted_nxt;
		end
	end

	assign status.fill = take_sample && (count_q == CNT_W'(N - 1));

	// deadzone window, signed so that bounds past either end are not wrapped
	assign med_s = $signed({2'b00, sorted_q[MID]});
	assign lo_s  = $signed({2'b00, center_q}) - $signed({3'b000, half_q});
	assign hi_s  = $signed({2'b00, center_q}) + $signed({3'b000, half_q});
	assign snapped = (dz_en_q && (med_s > lo_s) && (med_s < hi_s)) ? center_q
		: sorted_q[MID];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ready_q     <= 1'b0;
			changed_q   <= 1'b0;
			have_last_q <= 1'b0;
			last_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				done_q <= 1'b0;
			end
			if (cmd.step) begin
				if (mode_q == MODE_ACK) begin
					ready_q <= 1'b0;
				end else if (take_sample) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.eval) begin
				count_q <= '0;
				done_q  <= 1'b1;
				if (have_last_q && snapped == last_q) begin
					changed_q <= 1'b0;
				end else begin
					last_q      <= snapped;
					have_last_q <= 1'b1;
					changed_q   <= 1'b1;
					ready_q     <= 1'b1;
				end
			end
		end
	end

	// output register
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data <= {(OUT_W - VAL_W - 3)'(0), done_q, ready_q, changed_q, last_q};
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ test/tb_median_five_deadzone_change_detect_top.sv @@
module tb_median_five_deadzone_change_detect_top;
	import mfdcd_pkg::*;

	localparam int TDATA_W = ((ADC_BITS_DEF + 7) / 8) * 8;
	localparam int N_PHASES = 9;
	localparam int PHASE_ITEMS = 105;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             changed;
		logic             ready_res;
		logic             median_done;
	} filt_result_t;

	// Mirrors the filter: window, last reported value, flags and registers.
	// Each accepted input transfer pushes exactly one expected result.
	class median_scoreboard;
		logic              dz_en;
		logic [VAL_W-1:0]  center;
		logic [HALF_W-1:0] half;
		logic [VAL_W-1:0]  window[SAMPLES_DEF];
		int                fill;
		logic [VAL_W-1:0]  last_val;
		bit                have_last;
		bit                changed;
		bit                ready;
		filt_result_t      due_q[$];
		int errors, n_samples, n_acks, n_dropped, n_medians, n_changes, n_snaps, n_useful;

		function new();
			dz_en = 1'b0;
			center = CENTER_RST;
			half = HALF_RST;
			fill = 0;
			last_val = '0;
			have_last = 0;
			changed = 0;
			ready = 0;
			errors = 0;
			n_samples = 0;
			n_acks = 0;
			n_dropped = 0;
			n_medians = 0;
			n_changes = 0;
			n_snaps = 0;
			n_useful = 0;
		endfunction

		function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				CFG_DZ_EN: dz_en = data[0];
				CFG_CENTER: center = data[VAL_W-1:0];
				CFG_HALF: half = data[HALF_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_input(logic mode, logic [TDATA_W-1:0] data);
			logic [VAL_W-1:0] sorted[SAMPLES_DEF];
			logic [VAL_W-1:0] t;
			int i, j, med, lo, hi;
			bit done;
			filt_result_t r;
			done = 0;
			if (mode == MODE_ACK) begin
				if (ready)
					n_useful++;
				ready = 0;
				n_acks++;
			end else if (ready) begin
				n_dropped++;
			end else begin
				n_samples++;
				n_useful++;
				window[fill] = data[ADC_BITS_DEF-1 -: VAL_W];
				fill++;
				if (fill == SAMPLES_DEF) begin
					fill = 0;
					done = 1;
					n_medians++;
					sorted = window;
					for (i = 1; i < SAMPLES_DEF; i++) begin
						t = sorted[i];
						j = i;
						while (j > 0 && sorted[j-1] > t) begin
							sorted[j] = sorted[j-1];
							j--;
						end
						sorted[j] = t;
					end
					med = int'(sorted[SAMPLES_DEF/2]);
					if (dz_en) begin
						// bounds kept signed, no wrap below 0 or above 255
						lo = int'(center) - int'(half);
						hi = int'(center) + int'(half);
						if (med > lo && med < hi) begin
							med = int'(center);
							n_snaps++;
						end
					end
					if (have_last && med[VAL_W-1:0] == last_val) begin
						changed = 0;
					end else begin
						last_val = med[VAL_W-1:0];
						have_last = 1;
						changed = 1;
						ready = 1;
						n_changes++;
					end
				end
			end
			r.value = last_val;
			r.changed = changed;
			r.ready_res = ready;
			r.median_done = done;
			due_q.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			filt_result_t want;
			if (due_q.size() == 0) begin
				$error("result transfer with nothing pending: tdata 0x%h", d);
				errors++;
				return;
			end
			want = due_q.pop_front();
			if (d[VAL_W-1:0] !== want.value) begin
				$error("value: expected %0d, got %0d", want.value, d[VAL_W-1:0]);
				errors++;
			end
			if (d[VAL_W] !== want.changed) begin
				$error("changed: expected %0d, got %0d", want.changed, d[VAL_W]);
				errors++;
			end
			if (d[VAL_W+1] !== want.ready_res) begin
				$error("ready_res: expected %0d, got %0d", want.ready_res, d[VAL_W+1]);
				errors++;
			end
			if (d[VAL_W+2] !== want.median_done) begin
				$error("median_done: expected %0d, got %0d", want.median_done, d[VAL_W+2]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [TDATA_W-1:0]    s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_W-1:0]      m_axis_tdata;

	median_scoreboard sb = new();

	// stimulus knobs shared between processes
	int rx_hold = 0;
	bit tx_gaps = 1'b1;
	int cur_center = CENTER_RST;
	int cur_half = HALF_RST;

	median_five_deadzone_change_detect_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // sample, zero pad
		.s_axis_tuser  (s_axis_tuser),   // mode
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // value, changed, ready_res, median_done, pad
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both transfer monitors sample pre-edge values; input noted before result.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_input(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	// One input transfer, with an optional idle gap ahead of it.
	// tvalid is left high so the next item can follow back to back.
	task automatic send_item(input logic mode, input logic [ADC_BITS_DEF-1:0] smp);
		int gap;
		gap = tx_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {{(TDATA_W - ADC_BITS_DEF){1'b0}}, smp};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Sender stops and waits until every expected result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.due_q.size() != 0)
			@(posedge clk);
		// results can precede the block fully settling; allow its latency
		repeat (8) @(posedge clk);
	endtask

	task automatic write_settings(input int dz, input int ctr, input int hw);
		cfg_we <= 1'b1;
		cfg_addr <= CFG_DZ_EN;
		cfg_wdata <= CFG_DATA_W'(dz);
		@(posedge clk);
		sb.write_reg(CFG_DZ_EN, CFG_DATA_W'(dz));
		cfg_addr <= CFG_CENTER;
		cfg_wdata <= CFG_DATA_W'(ctr);
		@(posedge clk);
		sb.write_reg(CFG_CENTER, CFG_DATA_W'(ctr));
		cfg_addr <= CFG_HALF;
		cfg_wdata <= CFG_DATA_W'(hw);
		@(posedge clk);
		sb.write_reg(CFG_HALF, CFG_DATA_W'(hw));
		cfg_we <= 1'b0;
		cur_center = ctr;
		cur_half = hw;
	endtask

	// A window of five samples, usually followed by an acknowledge.
	// Levels: repeat of the last reported value (exercises the no-change path),
	// near the deadzone edges, or fully random. Some items are plain noise.
	task automatic send_burst();
		int kind, k, v;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			send_item(logic'($urandom_range(0, 1)), ADC_BITS_DEF'($urandom_range(0, 1023)));
			return;
		end
		for (k = 0; k < SAMPLES_DEF; k++) begin
			if (kind <= 3)
				v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : int'(sb.last_val);
			else if (kind <= 6)
				v = cur_center + $urandom_range(0, 2 * cur_half + 4) - cur_half - 2;
			else
				v = $urandom_range(0, 255);
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			send_item(MODE_SAMPLE, {v[VAL_W-1:0], 2'($urandom_range(0, 3))});
		end
		if ($urandom_range(0, 99) < 85)
			send_item(MODE_ACK, ADC_BITS_DEF'($urandom_range(0, 1023)));
	endtask

	// Result side: random stalls, long holds on request, eager stretches.
	initial begin
		int stall, eager_left, r;
		stall = 0;
		eager_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
			end else if (eager_left > 0) begin
				eager_left--;
				m_axis_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					m_axis_tready <= 1'b1;
				end else if (r < 85) begin
					m_axis_tready <= 1'b0;
					stall = $urandom_range(0, 2);
				end else if (r < 92) begin
					m_axis_tready <= 1'b0;
					stall = $urandom_range(10, 40);
				end else begin
					m_axis_tready <= 1'b1;
					eager_left = $urandom_range(100, 300);
				end
			end
		end
	end

	// Ack first while idle, a first median, a dropped sample, an equal
	// median, a stray ack, then all-ones samples and another dropped one.
	localparam logic [ADC_BITS_DEF:0] DIRECTED [21] = '{
		{MODE_ACK, 10'd1023}, {MODE_SAMPLE, 10'd0}, {MODE_SAMPLE, 10'd1023},
		{MODE_SAMPLE, 10'd512}, {MODE_SAMPLE, 10'd3}, {MODE_SAMPLE, 10'd1020},
		{MODE_SAMPLE, 10'd700}, {MODE_ACK, 10'd0}, {MODE_SAMPLE, 10'd513},
		{MODE_SAMPLE, 10'd514}, {MODE_SAMPLE, 10'd515}, {MODE_SAMPLE, 10'd512},
		{MODE_SAMPLE, 10'd1023}, {MODE_ACK, 10'h2aa}, {MODE_SAMPLE, 10'd1023},
		{MODE_SAMPLE, 10'd1023}, {MODE_SAMPLE, 10'd1023}, {MODE_SAMPLE, 10'd1022},
		{MODE_SAMPLE, 10'd1021}, {MODE_SAMPLE, 10'd700}, {MODE_ACK, 10'h155}
	};

	// Register sets per phase; -1 picks a random value. Extremes of centre
	// and half width push the deadzone bounds past both ends of the range.
	localparam int PH_DZ [N_PHASES]   = '{1, 1, 1, 1, 0, 1, 1, 1, 1};
	localparam int PH_CTR [N_PHASES]  = '{128, 0, 255, 255, 0, -1, -1, -1, 128};
	localparam int PH_HALF [N_PHASES] = '{4, 127, 127, 0, 0, -1, -1, -1, 1};

	initial begin
		int i, p, ctr, hw, goal;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		for (i = 0; i < 21; i++)
			send_item(DIRECTED[i][ADC_BITS_DEF], DIRECTED[i][ADC_BITS_DEF-1:0]);

		goal = 0;
		for (p = 0; p < N_PHASES; p++) begin
			drain();
			ctr = (PH_CTR[p] < 0) ? $urandom_range(0, 255) : PH_CTR[p];
			hw = (PH_HALF[p] < 0) ? $urandom_range(0, 127) : PH_HALF[p];
			write_settings(PH_DZ[p], ctr, hw);
			tx_gaps = (p % 3 != 0);
			// long result-side hold while input keeps coming: block backs up
			if (p % 3 == 1)
				rx_hold = 150;
			goal = sb.n_useful + PHASE_ITEMS;
			while (sb.n_useful < goal)
				send_burst();
		end
		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d samples (%0d dropped while ready) and %0d acknowledges",
			sb.n_samples, sb.n_dropped, sb.n_acks);
		$display("over %0d register sets: %0d medians, %0d changes, %0d deadzone snaps",
			N_PHASES + 1, sb.n_medians, sb.n_changes, sb.n_snaps);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
